### rtl/bbc_pkg.sv
// Package for the bracket balance checker.
// Holds the beat types, the stack entry type, the report codes and the byte classifier.
// Depends on nothing.
package bbc_pkg;

	// Report codes
	typedef enum logic [2:0] {
		KIND_MISSING   = 3'd0,
		KIND_MISMATCH  = 3'd1,
		KIND_UNMATCHED = 3'd2,
		KIND_SUMMARY   = 3'd3,
		KIND_OVERFLOW  = 3'd4
	} report_kind_t;

	// Bracket kinds: round, curly, square
	localparam logic [1:0] BR_ROUND  = 2'd0;
	localparam logic [1:0] BR_CURLY  = 2'd1;
	localparam logic [1:0] BR_SQUARE = 2'd2;

	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_beat_t;

	typedef struct packed {
		report_kind_t report_kind;
		logic [15:0]  opener_position;
		logic [15:0]  closer_position;
		logic [15:0]  error_total;
		logic         last_of_run;
	} report_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] position;
	} stack_entry_t;

	typedef struct packed {
		logic       is_open;
		logic       is_close;
		logic [1:0] kind;
	} char_class_t;

	function automatic char_class_t bbc_classify(input logic [7:0] b);
		char_class_t c;
		c = '{is_open: 1'b0, is_close: 1'b0, kind: BR_ROUND};
		case (b)
			CH_OPEN_ROUND:   c = '{is_open: 1'b1, is_close: 1'b0, kind: BR_ROUND};
			CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, kind: BR_CURLY};
			CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, kind: BR_SQUARE};
			CH_CLOSE_ROUND:  c = '{is_open: 1'b0, is_close: 1'b1, kind: BR_ROUND};
			CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: BR_CURLY};
			CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: BR_SQUARE};
			default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: BR_ROUND};
		endcase
		return c;
	endfunction

endpackage

### rtl/bbc_stack_mem.sv
// Opener stack storage: one write port, one read port, registered read data.
// Depends on bbc_pkg for the entry type.
module bbc_stack_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  bbc_pkg::stack_entry_t wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output bbc_pkg::stack_entry_t rd_data
);
	import bbc_pkg::*;

	stack_entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data registered on rd_en
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/bracket_balance_checker.sv
// Bracket balance checker: takes a text one byte per beat and reports missing openers,
// mismatched pairs, stack overflow and unmatched openers, then a summary at end of text.
// An opener or a non-bracket byte is taken without leaving the idle state; a closer that
// finds the stack empty and an overflowing opener each queue a report; any other closer
// reads the top opener from the synchronous stack memory and compares kinds, queuing a
// mismatch when they differ. An end-of-text beat drains the openers still held, one memory
// read per drained opener, then queues the summary. Input stalls until the sequencer is
// idle again. Openers are held in an internal memory of DEPTH entries; results pass
// through a one-beat output register, so a waiting result does not hold back input that gives no result.
// Depends on bbc_pkg and bbc_stack_mem.
module bracket_balance_checker #(
	parameter int DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_stall,
	input  bbc_pkg::text_beat_t   text_beat,
	output logic                  report_valid,
	input  logic                  report_stall,
	output bbc_pkg::report_beat_t report_beat
);
	import bbc_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CLOSE = 4'b0010,
		S_DRAIN = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t       state_q, state_d;
	logic [FW-1:0] fill_q, fill_d, fill_dec;
	logic [15:0]  pos_q, pos_d, pos_inc;
	logic [15:0]  err_q, err_d, err_inc;
	report_beat_t pend_q, pend_d;
	logic         pend_set;
	logic [1:0]   close_kind_q;
	logic         close_set;
	logic         report_valid_q;
	report_beat_t report_beat_q, out_data;
	logic         out_free, out_load;
	logic         text_fire, stack_full, stack_empty;
	char_class_t  cls;

	logic         wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	stack_entry_t wr_data, rd_data;

	assign text_stall = (state_q != S_IDLE);
	assign text_fire  = text_valid && !text_stall;
	assign out_free   = !report_valid_q || !report_stall;
	assign cls        = bbc_classify(text_beat.text_byte);

	assign fill_dec    = fill_q - FW'(1);
	assign stack_full  = (fill_q >= FW'(DEPTH));
	assign stack_empty = (fill_q == '0);
	assign pos_inc     = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;
	assign err_inc     = (err_q == POS_MAX) ? err_q : err_q + 16'd1;

	// stack memory ports; a pushed entry is never read in the cycle it is written
	assign wr_en   = text_fire && !text_beat.end_of_text && cls.is_open && !stack_full;
	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = '{kind: cls.kind, position: pos_inc};
	assign rd_addr = fill_dec[AW-1:0];
	assign rd_en   = (text_fire && !stack_empty
	                  && (text_beat.end_of_text || cls.is_close))
	                 || (state_q == S_DRAIN && out_free && !stack_empty);

	bbc_stack_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		pos_d     = pos_q;
		err_d     = err_q;
		pend_set  = 1'b0;
		pend_d    = pend_q;
		close_set = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (text_fire) begin
					if (text_beat.end_of_text) begin
						if (stack_empty) begin
							pend_set = 1'b1;
							pend_d   = '{KIND_SUMMARY, 16'd0, 16'd0, err_q, 1'b1};
							fill_d   = '0;
							pos_d    = '0;
							err_d    = '0;
							state_d  = S_EMIT;
						end else begin
							fill_d  = fill_dec;
							state_d = S_DRAIN;
						end
					end else begin
						pos_d = pos_inc;
						if (cls.is_open) begin
							if (!stack_full) begin
								fill_d = fill_q + FW'(1);
							end else begin
								err_d    = err_inc;
								pend_set = 1'b1;
								pend_d   = '{KIND_OVERFLOW, 16'd0, pos_inc, err_inc, 1'b1};
								state_d  = S_EMIT;
							end
						end else if (cls.is_close) begin
							if (stack_empty) begin
								err_d    = err_inc;
								pend_set = 1'b1;
								pend_d   = '{KIND_MISSING, 16'd0, pos_inc, err_inc, 1'b1};
								state_d  = S_EMIT;
							end else begin
								fill_d    = fill_dec;
								close_set = 1'b1;
								state_d   = S_CLOSE;
							end
						end
					end
				end
			end
			S_CLOSE: begin
				// top opener arrives from the memory this cycle
				if (rd_data.kind != close_kind_q) begin
					err_d    = err_inc;
					pend_set = 1'b1;
					pend_d   = '{KIND_MISMATCH, rd_data.position, pos_q, err_inc, 1'b1};
					state_d  = S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DRAIN: begin
				// one unmatched opener goes out per free output slot
				if (out_free) begin
					err_d = err_inc;
					if (!stack_empty) begin
						fill_d = fill_dec;
					end else begin
						pend_set = 1'b1;
						pend_d   = '{KIND_SUMMARY, 16'd0, 16'd0, err_inc, 1'b1};
						fill_d   = '0;
						pos_d    = '0;
						err_d    = '0;
						state_d  = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			pos_q   <= '0;
			err_q   <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			pos_q   <= pos_d;
			err_q   <= err_d;
		end
	end

	// held result and closer kind
	always_ff @(posedge clk) begin
		if (pend_set) begin
			pend_q <= pend_d;
		end
		if (close_set) begin
			close_kind_q <= cls.kind;
		end
	end

	// output register
	assign out_load = out_free && (state_q == S_EMIT || state_q == S_DRAIN);
	assign out_data = (state_q == S_EMIT) ? pend_q
	                : '{KIND_UNMATCHED, rd_data.position, 16'd0, err_inc, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (out_load) begin
			report_valid_q <= 1'b1;
		end else if (!report_stall) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			report_beat_q <= out_data;
		end
	end

	assign report_valid = report_valid_q;
	assign report_beat  = report_beat_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("stack fill beyond depth");

	a_summary_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && pend_q.report_kind == KIND_SUMMARY)
		|-> (fill_q == '0 && pos_q == '0 && err_q == '0))
		else $error("summary pending with state not cleared");

	a_unmatched_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && report_beat.report_kind == KIND_UNMATCHED)
		|-> !report_beat.last_of_run)
		else $error("unmatched opener marked last of run");

	a_drain_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && $past(state_q) == S_IDLE) |-> $past(text_beat.end_of_text))
		else $error("drain entered without end of text");

endmodule
